// ===== rtl/sswap_pkg.sv =====
// shared types and codes for the smallest-string-with-swaps block
package sswap_pkg;

	localparam int IDX_W  = 6;
	localparam int CHAR_W = 8;

	localparam logic [1:0] FUNC_APPEND = 2'd0;
	localparam logic [1:0] FUNC_PAIR   = 2'd1;
	localparam logic [1:0] FUNC_FINISH = 2'd2;

	typedef struct packed {
		logic [1:0]        func;
		logic [CHAR_W-1:0] char_value;
		logic [IDX_W-1:0]  index_a;
		logic [IDX_W-1:0]  index_b;
	} src_item_t;

	typedef struct packed {
		logic [CHAR_W-1:0] out_char;
		logic [IDX_W-1:0]  position;
		logic              last;
		logic              dropped;
		logic              empty_res;
	} res_item_t;

	typedef enum logic [1:0] {
		RD_A,
		RD_B,
		RD_SWEEP,
		RD_J
	} rd_sel_t;

	typedef struct packed {
		logic    take;
		rd_sel_t rd_sel;
		logic    lat_a;
		logic    lat_b;
		logic    sweep_clr;
		logic    sweep_run;
		logic    merge_wr;
		logic    lat_j;
		logic    p1_run;
		logic    p1_wr;
		logic    lat_i;
		logic    p2_run;
		logic    j_clr;
		logic    j_inc;
		logic    load_out;
		logic    load_empty;
		logic    finish_clr;
	} cmd_t;

	typedef struct packed {
		logic go_merge;
		logic go_fin;
		logic cnt_zero;
		logic ab_same;
		logic sweep_done;
		logic j_last;
		logic out_taken;
		logic out_last;
	} status_t;

endpackage

// ===== rtl/sswap_ram.sv =====
// generic simple dual-port ram with registered read
module sswap_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== rtl/sswap_dp.sv =====
// datapath: character, group label and order stores, counters, result register
module sswap_dp #(
	parameter int MAX_LEN = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sswap_pkg::src_item_t  src_item,
	input  logic                  res_stall,
	input  sswap_pkg::cmd_t       cmd,
	output sswap_pkg::status_t    st,
	output logic                  res_valid,
	output sswap_pkg::res_item_t  res_item
);
	import sswap_pkg::*;

	localparam int AW = $clog2(MAX_LEN);
	localparam int CW = $clog2(MAX_LEN + 1);

	logic [CW-1:0]     cnt_q;
	logic              drop_q;
	logic [AW-1:0]     ib_q, la_q, lb_q, lj_q, ki_q, kc_q, below_q, j_q, m_s1;
	logic [CHAR_W-1:0] cj_q, pick_q;
	logic [CW-1:0]     m_q;
	logic              v_s1;
	logic              out_v_q;
	res_item_t         out_q;

	logic [AW-1:0]     raddr;
	logic [CHAR_W-1:0] char_rd;
	logic [AW-1:0]     lab_rd;
	logic [2*AW-1:0]   rk_rd;
	logic              full, pair_ok, do_append, lab_we, mwr;
	logic [AW-1:0]     lab_waddr, lab_wdata;
	logic              in_grp, m_before_j;

	assign full      = cnt_q == CW'(MAX_LEN);
	assign pair_ok   = ((IDX_W+1)'(src_item.index_a) < (IDX_W+1)'(cnt_q)) &&
	                   ((IDX_W+1)'(src_item.index_b) < (IDX_W+1)'(cnt_q));
	assign do_append = cmd.take && src_item.func == FUNC_APPEND && !full;

	always_comb begin
		unique case (cmd.rd_sel)
			RD_A:     raddr = src_item.index_a[AW-1:0];
			RD_B:     raddr = ib_q;
			RD_SWEEP: raddr = m_q[AW-1:0];
			RD_J:     raddr = j_q;
			default:  raddr = j_q;
		endcase
	end

	// relabel pass: every member of group b takes label a
	assign mwr       = cmd.merge_wr && v_s1 && lab_rd == lb_q;
	assign lab_we    = do_append || mwr;
	assign lab_waddr = do_append ? cnt_q[AW-1:0] : m_s1;
	assign lab_wdata = do_append ? cnt_q[AW-1:0] : la_q;

	sswap_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_char (
		.clk(clk), .we(do_append), .waddr(cnt_q[AW-1:0]), .wdata(src_item.char_value),
		.raddr(raddr), .rdata(char_rd)
	);

	sswap_ram #(.WIDTH(AW), .DEPTH(MAX_LEN)) u_lab (
		.clk(clk), .we(lab_we), .waddr(lab_waddr), .wdata(lab_wdata),
		.raddr(raddr), .rdata(lab_rd)
	);

	// per position: count of earlier members, order of (char, index) in group
	sswap_ram #(.WIDTH(2*AW), .DEPTH(MAX_LEN)) u_rk (
		.clk(clk), .we(cmd.p1_wr), .waddr(j_q), .wdata({kc_q, below_q}),
		.raddr(raddr), .rdata(rk_rd)
	);

	assign in_grp     = v_s1 && lab_rd == lj_q;
	assign m_before_j = m_s1 < j_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			drop_q  <= 1'b0;
			m_q     <= '0;
			v_s1    <= 1'b0;
			j_q     <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (do_append) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.take && ((src_item.func == FUNC_APPEND && full) ||
			                 (src_item.func == FUNC_PAIR && !pair_ok))) begin
				drop_q <= 1'b1;
			end
			if (cmd.finish_clr) begin
				cnt_q  <= '0;
				drop_q <= 1'b0;
			end
			if (cmd.sweep_clr) begin
				m_q  <= '0;
				v_s1 <= 1'b0;
			end else if (cmd.sweep_run) begin
				if (m_q != cnt_q) begin
					m_q  <= m_q + 1'b1;
					v_s1 <= 1'b1;
				end else begin
					v_s1 <= 1'b0;
				end
			end
			if (cmd.j_clr) begin
				j_q <= '0;
			end else if (cmd.j_inc) begin
				j_q <= j_q + 1'b1;
			end
			if (cmd.load_out || cmd.load_empty) begin
				out_v_q <= 1'b1;
			end else if (out_v_q && !res_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		m_s1 <= m_q[AW-1:0];
		if (cmd.take) begin
			ib_q <= src_item.index_b[AW-1:0];
		end
		if (cmd.lat_a) begin
			la_q <= lab_rd;
		end
		if (cmd.lat_b) begin
			lb_q <= lab_rd;
		end
		if (cmd.lat_j) begin
			cj_q    <= char_rd;
			lj_q    <= lab_rd;
			kc_q    <= '0;
			below_q <= '0;
		end
		if (cmd.p1_run && in_grp) begin
			if (m_before_j) begin
				kc_q <= kc_q + 1'b1;
			end
			if (char_rd < cj_q || (char_rd == cj_q && m_before_j)) begin
				below_q <= below_q + 1'b1;
			end
		end
		if (cmd.lat_i) begin
			lj_q <= lab_rd;
			ki_q <= rk_rd[2*AW-1:AW];
		end
		if (cmd.p2_run && in_grp && rk_rd[AW-1:0] == ki_q) begin
			pick_q <= char_rd;
		end
		if (cmd.load_out) begin
			out_q.out_char  <= pick_q;
			out_q.position  <= IDX_W'(j_q);
			out_q.last      <= st.j_last;
			out_q.dropped   <= drop_q;
			out_q.empty_res <= 1'b0;
		end else if (cmd.load_empty) begin
			out_q.out_char  <= '0;
			out_q.position  <= '0;
			out_q.last      <= 1'b1;
			out_q.dropped   <= drop_q;
			out_q.empty_res <= 1'b1;
		end
	end

	assign st.go_merge   = src_item.func == FUNC_PAIR && pair_ok;
	assign st.go_fin     = src_item.func == FUNC_FINISH;
	assign st.cnt_zero   = cnt_q == '0;
	assign st.ab_same    = lab_rd == la_q;
	assign st.sweep_done = m_q == cnt_q && !v_s1;
	assign st.j_last     = CW'(j_q) == cnt_q - 1'b1;
	assign st.out_taken  = out_v_q && !res_stall;
	assign st.out_last   = out_q.last;

	assign res_valid = out_v_q;
	assign res_item  = out_q;
endmodule

// ===== rtl/sswap_ctrl.sv =====
// controller: sequences merge relabel passes and the two finish passes
module sswap_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_stall,
	input  sswap_pkg::status_t st,
	output sswap_pkg::cmd_t    cmd
);
	import sswap_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE = 11'b00000000001,
		S_MA   = 11'b00000000010,
		S_MB   = 11'b00000000100,
		S_MS   = 11'b00000001000,
		S_P1H  = 11'b00000010000,
		S_P1L  = 11'b00000100000,
		S_P1S  = 11'b00001000000,
		S_P2H  = 11'b00010000000,
		S_P2L  = 11'b00100000000,
		S_P2S  = 11'b01000000000,
		S_OUT  = 11'b10000000000
	} state_t;

	state_t state_q, state_d;

	assign src_stall = state_q != S_IDLE;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.rd_sel = RD_SWEEP;
		unique case (state_q)
			S_IDLE: begin
				cmd.rd_sel = RD_A;
				if (src_valid) begin
					cmd.take = 1'b1;
					if (st.go_merge) begin
						state_d = S_MA;
					end else if (st.go_fin) begin
						if (st.cnt_zero) begin
							cmd.load_empty = 1'b1;
							state_d        = S_OUT;
						end else begin
							cmd.j_clr = 1'b1;
							state_d   = S_P1H;
						end
					end
				end
			end
			S_MA: begin
				cmd.lat_a  = 1'b1;
				cmd.rd_sel = RD_B;
				state_d    = S_MB;
			end
			S_MB: begin
				cmd.lat_b     = 1'b1;
				cmd.sweep_clr = 1'b1;
				state_d       = st.ab_same ? S_IDLE : S_MS;
			end
			S_MS: begin
				cmd.sweep_run = 1'b1;
				cmd.merge_wr  = 1'b1;
				if (st.sweep_done) begin
					state_d = S_IDLE;
				end
			end
			S_P1H: begin
				cmd.rd_sel = RD_J;
				state_d    = S_P1L;
			end
			S_P1L: begin
				cmd.lat_j     = 1'b1;
				cmd.sweep_clr = 1'b1;
				state_d       = S_P1S;
			end
			S_P1S: begin
				cmd.sweep_run = 1'b1;
				cmd.p1_run    = 1'b1;
				if (st.sweep_done) begin
					cmd.p1_wr = 1'b1;
					if (st.j_last) begin
						cmd.j_clr = 1'b1;
						state_d   = S_P2H;
					end else begin
						cmd.j_inc = 1'b1;
						state_d   = S_P1H;
					end
				end
			end
			S_P2H: begin
				cmd.rd_sel = RD_J;
				state_d    = S_P2L;
			end
			S_P2L: begin
				cmd.lat_i     = 1'b1;
				cmd.sweep_clr = 1'b1;
				state_d       = S_P2S;
			end
			S_P2S: begin
				cmd.sweep_run = 1'b1;
				cmd.p2_run    = 1'b1;
				if (st.sweep_done) begin
					cmd.load_out = 1'b1;
					state_d      = S_OUT;
				end
			end
			S_OUT: begin
				if (st.out_taken) begin
					if (st.out_last) begin
						cmd.finish_clr = 1'b1;
						cmd.j_clr      = 1'b1;
						state_d        = S_IDLE;
					end else begin
						cmd.j_inc = 1'b1;
						state_d   = S_P2H;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

// ===== rtl/smallest_string_with_swaps.sv =====
// Smallest string reachable by swaps. Append items (func 0) store the character as a group
// of its own; items with an ignored selector are also taken without stalling the input. A
// swap pair (func 1) reads both group labels and then relabels the second group over all n
// loaded positions through the single read port of the label store. A finish item (func 2)
// runs two passes of one store sweep per position, then clears the store; an empty store
// gives one result flagged empty. Input stall is high for the whole of each multi-cycle
// item, and no item is taken while a result waits.
module smallest_string_with_swaps #(
	parameter int MAX_LEN = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 src_valid,
	output logic                 src_stall,
	input  sswap_pkg::src_item_t src_item,
	output logic                 res_valid,
	input  logic                 res_stall,
	output sswap_pkg::res_item_t res_item
);
	import sswap_pkg::*;

	cmd_t    cmd;
	status_t st;

	sswap_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .src_valid(src_valid), .src_stall(src_stall),
		.st(st), .cmd(cmd)
	);

	sswap_dp #(.MAX_LEN(MAX_LEN)) u_dp (
		.clk(clk), .arst_n(arst_n), .src_item(src_item), .res_stall(res_stall),
		.cmd(cmd), .st(st), .res_valid(res_valid), .res_item(res_item)
	);
endmodule

// ===== rtl/sswap_chk.sv =====
// port-level checks for the smallest-string-with-swaps block, with its bind
module sswap_chk (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 src_stall,
	input logic                 res_valid,
	input logic                 res_stall,
	input sswap_pkg::res_item_t res_item
);
	import sswap_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_item))
		else $error("stalled result item dropped or changed");

	a_no_take_while_res: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> src_stall)
		else $error("input item taken while a result waits");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.empty_res |-> res_item.last)
		else $error("empty result not marked last");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_stall && res_item.last |=> !res_valid && !src_stall)
		else $error("block not idle after last result item");
endmodule

bind smallest_string_with_swaps sswap_chk u_chk (
	.clk(clk), .arst_n(arst_n), .src_stall(src_stall),
	.res_valid(res_valid), .res_stall(res_stall), .res_item(res_item)
);
